@@ hw/rtl/imm_pkg.sv @@
`default_nettype none

package imm_pkg;

	localparam int MAX_DIM   = 8;
	localparam int IDX_W     = $clog2(MAX_DIM);
	localparam int ADDR_W    = 2 * IDX_W;
	localparam int DEPTH     = MAX_DIM * MAX_DIM;
	localparam int DATA_W    = 32;
	localparam int CNT_W     = 4;
	localparam int CFG_IDX_W = 2;

	localparam logic [1:0] ACT_WR_A = 2'd0;
	localparam logic [1:0] ACT_WR_B = 2'd1;
	localparam logic [1:0] ACT_MUL  = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_A_ROW = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_A_COL = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_B_ROW = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_B_COL = 2'd3;

	localparam logic [CNT_W-1:0] CNT_RESET = 4'd8;
	localparam logic [CNT_W-1:0] CNT_MAX   = 4'd8;

	typedef struct packed {
		logic [1:0]               action;
		logic [IDX_W-1:0]         row_index;
		logic [IDX_W-1:0]         col_index;
		logic signed [DATA_W-1:0] element_value;
	} req_item_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] product_value;
		logic [IDX_W-1:0]         out_row;
		logic [IDX_W-1:0]         out_col;
		logic                     size_error;
		logic                     last_result;
	} rsp_item_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic             wr_a;
		logic             wr_b;
		logic             rd;
		logic             first;
		logic [IDX_W-1:0] row;
		logic [IDX_W-1:0] col;
		logic [IDX_W-1:0] kk;
		logic             emit;
		logic             emit_err;
		logic             last;
	} dp_cmd_t;

	typedef struct packed {
		logic busy;
		logic out_free;
	} dp_status_t;

	// Zero counts as one, anything above the maximum is clamped.
	function automatic logic [CNT_W-1:0] eff_count(input logic [CNT_W-1:0] v);
		logic [CNT_W-1:0] r;
		if (v == '0) begin
			r = 4'd1;
		end else if (v > CNT_MAX) begin
			r = CNT_MAX;
		end else begin
			r = v;
		end
		return r;
	endfunction

endpackage

`default_nettype wire

@@ hw/rtl/imm_ctrl.sv @@
`default_nettype none

module imm_ctrl (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          req_valid,
	output logic                         req_ready,
	input  imm_pkg::req_item_t           req,
	input  wire                          cfg_valid,
	output logic                         cfg_ready,
	input  wire [imm_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire [imm_pkg::CNT_W-1:0]     cfg_data,
	output imm_pkg::dp_cmd_t             cmd,
	input  imm_pkg::dp_status_t          status
);
	import imm_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RUN  = 2'd1;
	localparam logic [1:0] ST_WAIT = 2'd2;
	localparam logic [1:0] ST_ERR  = 2'd3;

	logic [1:0]       state_q, state_d;
	logic [CNT_W-1:0] a_row_q, a_col_q, b_row_q, b_col_q;
	logic [IDX_W-1:0] i_q, i_d, j_q, j_d, k_q, k_d;
	logic [CNT_W-1:0] ar, ac, br, bc;
	logic             accept, i_last, j_last, k_last;

	assign cfg_ready = 1'b1;
	assign req_ready = (state_q == ST_IDLE);
	assign accept    = req_valid && req_ready;

	assign ar = eff_count(a_row_q);
	assign ac = eff_count(a_col_q);
	assign br = eff_count(b_row_q);
	assign bc = eff_count(b_col_q);

	assign i_last = ({1'b0, i_q} == ar - 4'd1);
	assign j_last = ({1'b0, j_q} == bc - 4'd1);
	assign k_last = ({1'b0, k_q} == ac - 4'd1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_row_q <= CNT_RESET;
			a_col_q <= CNT_RESET;
			b_row_q <= CNT_RESET;
			b_col_q <= CNT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_A_ROW: a_row_q <= cfg_data;
				CFG_A_COL: a_col_q <= cfg_data;
				CFG_B_ROW: b_row_q <= cfg_data;
				CFG_B_COL: b_col_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		state_d = state_q;
		i_d = i_q;
		j_d = j_q;
		k_d = k_q;
		cmd = '0;
		cmd.row = i_q;
		cmd.col = j_q;
		cmd.kk = k_q;
		cmd.first = (k_q == '0);
		cmd.last = i_last && j_last;
		unique case (state_q)
			ST_IDLE: begin
				cmd.wr_a = accept && (req.action == ACT_WR_A);
				cmd.wr_b = accept && (req.action == ACT_WR_B);
				if (accept && req.action == ACT_MUL) begin
					i_d = '0;
					j_d = '0;
					k_d = '0;
					state_d = (ac != br) ? ST_ERR : ST_RUN;
				end
			end
			ST_RUN: begin
				cmd.rd = 1'b1;
				if (k_last) begin
					k_d = '0;
					state_d = ST_WAIT;
				end else begin
					k_d = k_q + 1'b1;
				end
			end
			ST_WAIT: begin
				// The sum is complete once the read and multiply stages are empty.
				if (!status.busy && status.out_free) begin
					cmd.emit = 1'b1;
					if (i_last && j_last) begin
						state_d = ST_IDLE;
					end else begin
						state_d = ST_RUN;
						if (j_last) begin
							j_d = '0;
							i_d = i_q + 1'b1;
						end else begin
							j_d = j_q + 1'b1;
						end
					end
				end
			end
			ST_ERR: begin
				if (status.out_free) begin
					cmd.emit_err = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			i_q <= '0;
			j_q <= '0;
			k_q <= '0;
		end else begin
			state_q <= state_d;
			i_q <= i_d;
			j_q <= j_d;
			k_q <= k_d;
		end
	end

endmodule

`default_nettype wire

@@ hw/rtl/imm_datapath.sv @@
`default_nettype none

module imm_datapath (
	input  wire                  clk,
	input  wire                  arst_n,
	input  imm_pkg::req_item_t   req,
	input  imm_pkg::dp_cmd_t     cmd,
	output imm_pkg::dp_status_t  status,
	output logic                 rsp_valid,
	input  wire                  rsp_ready,
	output imm_pkg::rsp_item_t   rsp
);
	import imm_pkg::*;

	logic [DATA_W-1:0] mem_a [DEPTH];
	logic [DATA_W-1:0] mem_b [DEPTH];

	logic [ADDR_W-1:0] wr_addr, rd_addr_a, rd_addr_b;
	logic [DATA_W-1:0] a_s1, b_s1, prod_s2, acc_q;
	logic              valid_s1, first_s1, valid_s2, first_s2;
	logic              out_valid_q;
	rsp_item_t         out_q;

	assign wr_addr   = {req.row_index, req.col_index};
	assign rd_addr_a = {cmd.row, cmd.kk};
	assign rd_addr_b = {cmd.kk, cmd.col};

	always_ff @(posedge clk) begin
		if (cmd.wr_a) begin
			mem_a[wr_addr] <= req.element_value;
		end
		if (cmd.rd) begin
			a_s1 <= mem_a[rd_addr_a];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.wr_b) begin
			mem_b[wr_addr] <= req.element_value;
		end
		if (cmd.rd) begin
			b_s1 <= mem_b[rd_addr_b];
		end
	end

	// Only the low 32 bits of each product matter for a wrapping sum.
	always_ff @(posedge clk) begin
		prod_s2 <= a_s1 * b_s1;
		if (valid_s2) begin
			acc_q <= first_s2 ? prod_s2 : acc_q + prod_s2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			first_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			first_s2 <= 1'b0;
		end else begin
			valid_s1 <= cmd.rd;
			first_s1 <= cmd.first;
			valid_s2 <= valid_s1;
			first_s2 <= first_s1;
		end
	end

	assign status.busy     = valid_s1 || valid_s2;
	assign status.out_free = !out_valid_q || rsp_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit || cmd.emit_err) begin
			out_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_q.product_value <= acc_q;
			out_q.out_row <= cmd.row;
			out_q.out_col <= cmd.col;
			out_q.size_error <= 1'b0;
			out_q.last_result <= cmd.last;
		end else if (cmd.emit_err) begin
			out_q.product_value <= '0;
			out_q.out_row <= '0;
			out_q.out_col <= '0;
			out_q.size_error <= 1'b1;
			out_q.last_result <= 1'b1;
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

endmodule

`default_nettype wire

@@ hw/rtl/integer_matrix_multiply_core.sv @@
`default_nettype none

// Integer matrix multiplier. A request beat either writes one element of
// the A or B store (one beat per cycle while idle) or starts a multiply
// of A (a_row_count by a_col_count) with B (b_row_count by b_col_count).
// A multiply streams the product elements in row-major order with their
// coordinates, last_result set on the final one; mismatched inner
// dimensions give a single beat with size_error set. Products wrap to
// 32 bits. During a multiply each product element reads one A and one B
// entry per cycle through a single shared multiplier and accumulator,
// then waits out the two-stage read and multiply pipeline. No new request
// is taken during a multiply. Configuration writes are taken at any time
// but must only be made while the block is idle.
module integer_matrix_multiply_core (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          req_valid,
	output logic                         req_ready,
	input  imm_pkg::req_item_t           req,
	output logic                         rsp_valid,
	input  wire                          rsp_ready,
	output imm_pkg::rsp_item_t           rsp,
	input  wire                          cfg_valid,
	output logic                         cfg_ready,
	input  wire [imm_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire [imm_pkg::CNT_W-1:0]     cfg_data
);
	import imm_pkg::*;

	dp_cmd_t    cmd;
	dp_status_t status;

	imm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.status    (status)
	);

	imm_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd       (cmd),
		.status    (status),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

`ifndef NO_ASSERTIONS
	a_err_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.size_error |-> rsp.last_result)
		else $error("error beat without last_result");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.size_error |-> (rsp.product_value == '0) &&
		(rsp.out_row == '0) && (rsp.out_col == '0))
		else $error("error beat carries nonzero fields");

	a_mul_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && (req.action == ACT_MUL) |=> !req_ready)
		else $error("request taken right after a multiply started");
`endif

endmodule

`default_nettype wire
